@@ rtl/rmrc_pkg.sv @@
package rmrc_pkg;

    localparam int TIME_W  = 32;
    localparam int RAMP_W  = 10;
    localparam int PAUSE_W = 12;
    localparam int DUTY_W  = 4;
    localparam int DRIVE_W = 8;

    localparam logic [TIME_W-1:0]  DEADLINE_RST = TIME_W'(1000);
    localparam logic [DUTY_W-1:0]  DUTY_MAX     = DUTY_W'(10);
    localparam logic [DUTY_W-1:0]  DUTY_ONE     = DUTY_W'(1);
    localparam logic [DUTY_W-1:0]  MAX_DUTY_RST = DUTY_W'(6);
    localparam logic [DRIVE_W-1:0] DRIVE_OFF    = DRIVE_W'(255);

    // input tdata layout, lowest bit first
    localparam int IN_NOW_LSB   = 0;
    localparam int IN_SW1_BIT   = IN_NOW_LSB + TIME_W;
    localparam int IN_SW2_BIT   = IN_SW1_BIT + 1;
    localparam int IN_RDIR_BIT  = IN_SW2_BIT + 1;
    localparam int IN_RAMP_LSB  = IN_RDIR_BIT + 1;
    localparam int IN_PAUSE_LSB = IN_RAMP_LSB + RAMP_W;
    localparam int IN_USED_W    = IN_PAUSE_LSB + PAUSE_W;
    localparam int IN_W         = ((IN_USED_W + 7) / 8) * 8;

    // output tdata layout, lowest bit first
    localparam int OUT_DRV1_LSB = 0;
    localparam int OUT_DRV2_LSB = OUT_DRV1_LSB + DRIVE_W;
    localparam int OUT_MODE_LSB = OUT_DRV2_LSB + DRIVE_W;
    localparam int OUT_DIR_BIT  = OUT_MODE_LSB + 2;
    localparam int OUT_USED_W   = OUT_DIR_BIT + 1;
    localparam int OUT_W        = ((OUT_USED_W + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = DUTY_W;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP     = 1'b1;

    typedef enum logic [1:0] {
        MODE_PAUSE = 2'd0,
        MODE_UP    = 2'd1,
        MODE_DOWN  = 2'd2
    } t_mode;

    // floor(255 * (10 - d) / 10), inverted PWM
    function automatic logic [DRIVE_W-1:0] line_value(input logic [DUTY_W-1:0] d);
        logic [DRIVE_W-1:0] v;
        unique case (d)
            4'd0:    v = 8'd255;
            4'd1:    v = 8'd229;
            4'd2:    v = 8'd204;
            4'd3:    v = 8'd178;
            4'd4:    v = 8'd153;
            4'd5:    v = 8'd127;
            4'd6:    v = 8'd102;
            4'd7:    v = 8'd76;
            4'd8:    v = 8'd51;
            4'd9:    v = 8'd25;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/random_motor_ramp_controller.sv @@
// The result appears in the cycle after its input transaction while the result register is free.
// Throughput: one transaction per cycle while downstream is ready; the mode update is a
// single pass of combinational logic into the state and result registers.
// A skid entry absorbs one transaction during a downstream stall; o_s_tready then
// drops until the skid moves into the result register.
// Reset: synchronous, active low; pause mode, duty 0, deadline 1000, max duty 6.
module random_motor_ramp_controller (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // now_ms, first_switch_pressed, second_switch_pressed, random_direction,
    // ramp_ms, pause_ms, zero pad
    input  logic [rmrc_pkg::IN_W-1:0]     i_s_tdata,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // drive_first, drive_second, mode_now, direction_now, zero pad
    output logic [rmrc_pkg::OUT_W-1:0]    o_m_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rmrc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rmrc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int TW = rmrc_pkg::TIME_W;
    localparam int DW = rmrc_pkg::DUTY_W;

    // configuration
    logic [DW-1:0] r_max_duty;
    logic          r_swap;

    // controller state
    rmrc_pkg::t_mode r_mode, n_mode;
    logic            r_dir, n_dir;
    logic [DW-1:0]   r_duty, n_duty;
    logic [TW-1:0]   r_deadline, n_deadline;
    logic [rmrc_pkg::RAMP_W-1:0] r_ramp, n_ramp;

    // output stage
    logic                       r_ov, r_sv;
    logic [rmrc_pkg::OUT_W-1:0] r_od, r_sd;
    logic [rmrc_pkg::OUT_W-1:0] n_res;

    logic acc_in, take;

    logic [TW-1:0]                now;
    logic                         sw1, sw2, rdir;
    logic [rmrc_pkg::RAMP_W-1:0]  rramp;
    logic [rmrc_pkg::PAUSE_W-1:0] rpause;

    logic                         set_one, set_zero;
    logic [DW-1:0]                maxd;
    logic [rmrc_pkg::RAMP_W-1:0]  ramp_src;
    logic [TW:0]                  ramp_sum;
    logic [TW-1:0]                pause_sum;
    logic                         hit, drive_on;
    logic [rmrc_pkg::DRIVE_W-1:0] lv, drv1, drv2;

    assign now    = i_s_tdata[rmrc_pkg::IN_NOW_LSB +: TW];
    assign sw1    = i_s_tdata[rmrc_pkg::IN_SW1_BIT];
    assign sw2    = i_s_tdata[rmrc_pkg::IN_SW2_BIT];
    assign rdir   = i_s_tdata[rmrc_pkg::IN_RDIR_BIT];
    assign rramp  = i_s_tdata[rmrc_pkg::IN_RAMP_LSB +: rmrc_pkg::RAMP_W];
    assign rpause = i_s_tdata[rmrc_pkg::IN_PAUSE_LSB +: rmrc_pkg::PAUSE_W];

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_sv;
    assign acc_in      = i_s_tvalid && o_s_tready;
    assign take        = r_ov && i_m_tready;
    assign o_m_tvalid  = r_ov;
    assign o_m_tdata   = r_od;

    assign set_one  = r_swap ? sw2 : sw1;
    assign set_zero = r_swap ? sw1 : sw2;
    assign maxd     = (r_max_duty > rmrc_pkg::DUTY_MAX) ? rmrc_pkg::DUTY_MAX : r_max_duty;

    // one ramp adder serves both pause exit and speed-up exit; its carry tells
    // whether the new deadline already lies behind now
    assign ramp_src  = (r_mode == rmrc_pkg::MODE_PAUSE) ? rramp : r_ramp;
    assign ramp_sum  = {1'b0, now} + (TW + 1)'(ramp_src);
    assign pause_sum = now + TW'(rpause);

    always_comb begin
        n_mode     = r_mode;
        n_dir      = r_dir;
        n_duty     = r_duty;
        n_deadline = r_deadline;
        n_ramp     = r_ramp;
        hit        = now > r_deadline;
        drive_on   = 1'b0;

        if (set_one) begin
            n_dir = 1'b1;
        end
        if (set_zero) begin
            n_dir = 1'b0;
        end

        if (n_mode == rmrc_pkg::MODE_PAUSE) begin
            n_duty = '0;
            if (hit) begin
                n_dir      = rdir;
                n_ramp     = rramp;
                n_deadline = ramp_sum[TW-1:0];
                n_mode     = rmrc_pkg::MODE_UP;
                hit        = ramp_sum[TW];
            end
        end
        if (n_mode == rmrc_pkg::MODE_UP) begin
            if (n_duty < maxd) begin
                n_duty = n_duty + DW'(1);
            end
            drive_on = 1'b1;
            if (hit) begin
                n_deadline = ramp_sum[TW-1:0];
                n_mode     = rmrc_pkg::MODE_DOWN;
                hit        = ramp_sum[TW];
            end
        end
        if (n_mode == rmrc_pkg::MODE_DOWN) begin
            if (n_duty > rmrc_pkg::DUTY_ONE) begin
                n_duty = n_duty - DW'(1);
            end
            drive_on = 1'b1;
            if (hit) begin
                n_deadline = pause_sum;
                n_mode     = rmrc_pkg::MODE_PAUSE;
            end
        end

        lv   = rmrc_pkg::line_value(n_duty);
        drv1 = (drive_on && !n_dir) ? lv : rmrc_pkg::DRIVE_OFF;
        drv2 = (drive_on && n_dir)  ? lv : rmrc_pkg::DRIVE_OFF;

        n_res = '0;
        n_res[rmrc_pkg::OUT_DRV1_LSB +: rmrc_pkg::DRIVE_W] = drv1;
        n_res[rmrc_pkg::OUT_DRV2_LSB +: rmrc_pkg::DRIVE_W] = drv2;
        n_res[rmrc_pkg::OUT_MODE_LSB +: 2]                 = n_mode;
        n_res[rmrc_pkg::OUT_DIR_BIT]                       = n_dir;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_duty <= rmrc_pkg::MAX_DUTY_RST;
            r_swap     <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                rmrc_pkg::CFG_MAX_DUTY: r_max_duty <= i_cfg_data;
                rmrc_pkg::CFG_SWAP:     r_swap     <= i_cfg_data[0];
                default:                ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= rmrc_pkg::MODE_PAUSE;
            r_dir      <= 1'b0;
            r_duty     <= '0;
            r_deadline <= rmrc_pkg::DEADLINE_RST;
            r_ramp     <= '0;
        end else if (acc_in) begin
            r_mode     <= n_mode;
            r_dir      <= n_dir;
            r_duty     <= n_duty;
            r_deadline <= n_deadline;
            r_ramp     <= n_ramp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (take || !r_ov) begin
            // output slot frees: drain skid first, else load the new result
            if (r_sv) begin
                r_od <= r_sd;
                r_sv <= 1'b0;
                r_ov <= 1'b1;
            end else begin
                r_ov <= acc_in;
                if (acc_in) begin
                    r_od <= n_res;
                end
            end
        end else if (acc_in) begin
            // hold the stalled result, park the new one
            r_sv <= 1'b1;
            r_sd <= n_res;
        end
    end

endmodule

@@ rtl/rmrc_checker.sv @@
module rmrc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic [rmrc_pkg::OUT_W-1:0]    o_m_tdata,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready
);

    logic       out_dir;
    logic [1:0] out_mode;
    logic [rmrc_pkg::DRIVE_W-1:0] out_drv1, out_drv2;

    assign out_dir  = o_m_tdata[rmrc_pkg::OUT_DIR_BIT];
    assign out_mode = o_m_tdata[rmrc_pkg::OUT_MODE_LSB +: 2];
    assign out_drv1 = o_m_tdata[rmrc_pkg::OUT_DRV1_LSB +: rmrc_pkg::DRIVE_W];
    assign out_drv2 = o_m_tdata[rmrc_pkg::OUT_DRV2_LSB +: rmrc_pkg::DRIVE_W];

    // stalled result holds its data
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("result changed while stalled");

    // no result without an accepted transaction
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid && !(i_s_tvalid && o_s_tready) |=> !o_m_tvalid)
        else $error("result without input transaction");

    // the line not selected by direction is always off
    a_idle_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (out_dir ? (out_drv1 == rmrc_pkg::DRIVE_OFF)
                                : (out_drv2 == rmrc_pkg::DRIVE_OFF)))
        else $error("inactive motor line driven");

    // mode code three never appears
    a_mode_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (out_mode != 2'd3))
        else $error("invalid mode reported");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind random_motor_ramp_controller rmrc_checker u_rmrc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready)
);
